// ----- rtl/bap_pkg.sv -----
// Shared types and constants of the LE advertising report parser.
// Used by the front end, the queue, the back end and the top level.
package bap_pkg;

  // Widths of the report fields
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned NAME_LEN_W  = 5;
  localparam int unsigned ADDR_W      = 48;

  // Default configuration of the top level
  localparam int unsigned MAX_DATA_BYTES_DEF = 31;
  localparam int unsigned QUEUE_DEPTH_DEF    = 4;
  localparam logic [NAME_LEN_W-1:0] MAX_NAME_LEN_RST = 5'd30;

  // Byte positions in the report header
  localparam int unsigned POS_ADDR_TYPE = 1;
  localparam int unsigned POS_DATA_LEN  = 8;
  localparam int unsigned HDR_BYTES     = 9;

  // Header limits and AD types
  localparam logic [DATA_W-1:0] EVT_TYPE_MAX     = 8'd6;
  localparam logic [DATA_W-1:0] ADDR_TYPE_MAX    = 8'd1;
  localparam logic [DATA_W-1:0] AD_SHORT_NAME    = 8'h08;
  localparam logic [DATA_W-1:0] AD_COMPLETE_NAME = 8'h09;

  // Result kinds
  localparam logic RK_CHAR    = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  // Summary status codes
  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_BAD_EVENT     = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR_TYPE = 2'd2;
  localparam logic [1:0] ST_BAD_DATA_LEN  = 2'd3;

  // Name status codes
  localparam logic [1:0] NS_FOUND     = 2'd0;
  localparam logic [1:0] NS_NOT_FOUND = 2'd1;
  localparam logic [1:0] NS_MALFORMED = 2'd2;
  localparam logic [1:0] NS_TOO_LONG  = 2'd3;

  // Byte class decided by the front end
  typedef enum logic [2:0] {
    OP_EVENT,
    OP_ADDR_TYPE,
    OP_ADDR,
    OP_DATA_LEN,
    OP_DATA,
    OP_RSSI
  } op_e;

  // One queued byte
  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] data;
  } q_entry_t;

  // One result item
  typedef struct packed {
    logic                  result_kind;
    logic [DATA_W-1:0]     name_char;
    logic [1:0]            status;
    logic [2:0]            event_type_out;
    logic                  address_type_out;
    logic [ADDR_W-1:0]     device_address_out;
    logic signed [7:0]     rssi;
    logic [1:0]            name_status;
    logic [NAME_LEN_W-1:0] name_length;
  } result_t;

endpackage

// ----- rtl/bap_in_if.sv -----
// Input byte channel of the advertising report parser: valid/ready plus payload.
// No dependencies.
interface bap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       report_start;

  modport source (output valid, data_byte, report_start, input ready);
  modport sink   (input valid, data_byte, report_start, output ready);
endinterface

// ----- rtl/bap_out_if.sv -----
// Result channel of the advertising report parser: valid/ready plus payload.
// No dependencies.
interface bap_out_if;
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [7:0]        name_char;
  logic [1:0]        status;
  logic [2:0]        event_type_out;
  logic              address_type_out;
  logic [47:0]       device_address_out;
  logic signed [7:0] rssi;
  logic [1:0]        name_status;
  logic [4:0]        name_length;

  modport source (output valid, result_kind, name_char, status, event_type_out,
                  address_type_out, device_address_out, rssi, name_status,
                  name_length, input ready);
  modport sink   (input valid, result_kind, name_char, status, event_type_out,
                  address_type_out, device_address_out, rssi, name_status,
                  name_length, output ready);
endinterface

// ----- rtl/bap_front.sv -----
// Front end: accepts report bytes, tracks header position and report end,
// drops idle bytes and tags each kept byte with its class. Uses bap_pkg, bap_in_if.
module bap_front import bap_pkg::*; #(
  parameter int unsigned MaxDataBytes = MAX_DATA_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bap_in_if.sink   in_i,
  input  logic     q_full_i,
  output logic     push_o,
  output q_entry_t entry_o
);

  localparam int unsigned LenW = $clog2(MaxDataBytes + 1);
  localparam int unsigned PosW = $clog2(HDR_BYTES + MaxDataBytes + 2);

  logic [PosW-1:0] pos_q, pos_d;
  logic [LenW-1:0] len_q, len_d;
  logic            waiting_q, waiting_d;
  logic            accept;
  logic [PosW-1:0] data_end;
  logic [DATA_W-1:0] b;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign data_end   = PosW'(HDR_BYTES) + PosW'(len_q);

  // Classify the accepted byte
  always_comb begin
    pos_d         = pos_q;
    len_d         = len_q;
    waiting_d     = waiting_q;
    push_o        = 1'b0;
    entry_o.op    = OP_DATA;
    entry_o.data  = b;
    if (accept) begin
      if (in_i.report_start) begin
        push_o     = 1'b1;
        entry_o.op = OP_EVENT;
        pos_d      = PosW'(1);
        waiting_d  = (b > EVT_TYPE_MAX);
      end else if (!waiting_q) begin
        push_o = 1'b1;
        pos_d  = pos_q + PosW'(1);
        priority if (pos_q == PosW'(POS_ADDR_TYPE)) begin
          entry_o.op = OP_ADDR_TYPE;
          waiting_d  = (b > ADDR_TYPE_MAX);
        end else if (pos_q < PosW'(POS_DATA_LEN)) begin
          entry_o.op = OP_ADDR;
        end else if (pos_q == PosW'(POS_DATA_LEN)) begin
          entry_o.op = OP_DATA_LEN;
          if (b > DATA_W'(MaxDataBytes)) begin
            waiting_d = 1'b1;
          end else begin
            len_d = b[LenW-1:0];
          end
        end else if (pos_q < data_end) begin
          entry_o.op = OP_DATA;
        end else begin
          entry_o.op = OP_RSSI;
          waiting_d  = 1'b1;
        end
      end
    end
  end

  // Position and report tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      len_q     <= '0;
      waiting_q <= 1'b1;
    end else begin
      pos_q     <= pos_d;
      len_q     <= len_d;
      waiting_q <= waiting_d;
    end
  end

  // Checks
  a_idle_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_i.report_start && waiting_q) |-> !push_o)
    else $error("byte pushed while waiting for report start");

  a_rssi_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && entry_o.op == OP_RSSI) |=> waiting_q)
    else $error("report end did not return to waiting");

  a_pos_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !waiting_q |-> (pos_q != '0))
    else $error("active report at position zero");

endmodule

// ----- rtl/bap_queue.sv -----
// Short FIFO between front and back end so that each side stalls on its own.
// Uses bap_pkg.
module bap_queue import bap_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t entry_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_entry_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign push    = push_i && !full_o;
  assign pop     = pop_i && valid_o;
  assign entry_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push && count_q == CntW'(1)) |=> !valid_o)
    else $error("queue not empty after last entry left");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop && count_q == CntW'(Depth - 1)) |=> full_o)
    else $error("queue not full after last slot taken");

endmodule

// ----- rtl/bap_back.sv -----
// Back end: carries out classified bytes, keeps the header fields, walks the
// AD structures and drives the result register. Uses bap_pkg, bap_out_if.
module bap_back import bap_pkg::*; #(
  parameter int unsigned MaxDataBytes = MAX_DATA_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  q_entry_t              q_entry_i,
  output logic                  q_pop_o,
  input  logic [NAME_LEN_W-1:0] max_name_len_i,
  bap_out_if.source             out_o
);

  localparam int unsigned LenW = $clog2(MaxDataBytes + 1);

  typedef enum logic [1:0] {PH_LEN, PH_TYPE, PH_VALUE, PH_DONE} phase_e;

  phase_e                phase_q, phase_d;
  logic [2:0]            event_q, event_d;
  logic                  kind_q, kind_d;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic [LenW-1:0]       data_left_q, data_left_d;
  logic [LenW-1:0]       field_left_q, field_left_d;
  logic                  in_name_q, in_name_d;
  logic [1:0]            name_res_q, name_res_d;
  logic [NAME_LEN_W-1:0] name_cnt_q, name_cnt_d;
  result_t               out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic [DATA_W-1:0] b;
  logic              pop;
  logic              sum, chr;
  logic [1:0]        sum_status;
  logic [DATA_W-1:0] sum_rssi;
  logic [LenW-1:0]   rem_after;
  logic [LenW-1:0]   fl_dec;
  result_t           res;

  assign b         = q_entry_i.data;
  assign pop       = q_valid_i && (!out_valid_q || out_o.ready);
  assign q_pop_o   = pop;
  assign rem_after = data_left_q - LenW'(1);
  assign fl_dec    = field_left_q - LenW'(1);

  // Next state of the report and of the structure walk
  always_comb begin
    phase_d      = phase_q;
    event_d      = event_q;
    kind_d       = kind_q;
    addr_d       = addr_q;
    data_left_d  = data_left_q;
    field_left_d = field_left_q;
    in_name_d    = in_name_q;
    name_res_d   = name_res_q;
    name_cnt_d   = name_cnt_q;
    sum          = 1'b0;
    chr          = 1'b0;
    sum_status   = ST_OK;
    sum_rssi     = '0;
    if (pop) begin
      unique case (q_entry_i.op)
        OP_EVENT: begin
          event_d      = b[2:0];
          kind_d       = 1'b0;
          addr_d       = '0;
          data_left_d  = '0;
          phase_d      = PH_LEN;
          field_left_d = '0;
          in_name_d    = 1'b0;
          name_res_d   = NS_NOT_FOUND;
          name_cnt_d   = '0;
          if (b > EVT_TYPE_MAX) begin
            sum        = 1'b1;
            sum_status = ST_BAD_EVENT;
          end
        end
        OP_ADDR_TYPE: begin
          kind_d = b[0];
          if (b > ADDR_TYPE_MAX) begin
            sum        = 1'b1;
            sum_status = ST_BAD_ADDR_TYPE;
          end
        end
        OP_ADDR: begin
          // first byte ends up least significant after six shifts
          addr_d = {b, addr_q[ADDR_W-1:DATA_W]};
        end
        OP_DATA_LEN: begin
          if (b > DATA_W'(MaxDataBytes)) begin
            sum        = 1'b1;
            sum_status = ST_BAD_DATA_LEN;
          end else begin
            data_left_d = b[LenW-1:0];
          end
        end
        OP_DATA: begin
          data_left_d = rem_after;
          unique case (phase_q)
            PH_LEN: begin
              // zero length or structure past the data end is malformed
              if (b == '0 || b > DATA_W'(rem_after)) begin
                name_res_d = NS_MALFORMED;
                phase_d    = PH_DONE;
              end else begin
                field_left_d = b[LenW-1:0];
                phase_d      = PH_TYPE;
              end
            end
            PH_TYPE: begin
              field_left_d = fl_dec;
              if (b == AD_SHORT_NAME || b == AD_COMPLETE_NAME) begin
                if (fl_dec > LenW'(max_name_len_i)) begin
                  name_res_d = NS_TOO_LONG;
                  phase_d    = PH_DONE;
                end else begin
                  name_res_d = NS_FOUND;
                  in_name_d  = 1'b1;
                  phase_d    = (fl_dec == '0) ? PH_DONE : PH_VALUE;
                end
              end else begin
                in_name_d = 1'b0;
                phase_d   = (fl_dec == '0) ? PH_LEN : PH_VALUE;
              end
            end
            PH_VALUE: begin
              field_left_d = fl_dec;
              if (in_name_q) begin
                chr        = 1'b1;
                name_cnt_d = name_cnt_q + NAME_LEN_W'(1);
              end
              if (fl_dec == '0) begin
                phase_d = in_name_q ? PH_DONE : PH_LEN;
              end
            end
            PH_DONE: begin
            end
            default: begin
            end
          endcase
        end
        OP_RSSI: begin
          sum      = 1'b1;
          sum_rssi = b;
        end
        default: begin
        end
      endcase
    end
  end

  // Result item
  always_comb begin
    res = '0;
    if (sum) begin
      res.result_kind        = RK_SUMMARY;
      res.status             = sum_status;
      res.event_type_out     = event_d;
      res.address_type_out   = kind_d;
      res.device_address_out = addr_d;
      res.rssi               = sum_rssi;
      res.name_status        = name_res_d;
      res.name_length        = name_cnt_d;
    end else begin
      res.result_kind = RK_CHAR;
      res.name_char   = b;
    end
  end

  // Output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (pop && (sum || chr)) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LEN;
      event_q      <= '0;
      kind_q       <= 1'b0;
      addr_q       <= '0;
      data_left_q  <= '0;
      field_left_q <= '0;
      in_name_q    <= 1'b0;
      name_res_q   <= NS_NOT_FOUND;
      name_cnt_q   <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      event_q      <= event_d;
      kind_q       <= kind_d;
      addr_q       <= addr_d;
      data_left_q  <= data_left_d;
      field_left_q <= field_left_d;
      in_name_q    <= in_name_d;
      name_res_q   <= name_res_d;
      name_cnt_q   <= name_cnt_d;
      out_q        <= out_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.result_kind        = out_q.result_kind;
  assign out_o.name_char          = out_q.name_char;
  assign out_o.status             = out_q.status;
  assign out_o.event_type_out     = out_q.event_type_out;
  assign out_o.address_type_out   = out_q.address_type_out;
  assign out_o.device_address_out = out_q.device_address_out;
  assign out_o.rssi               = out_q.rssi;
  assign out_o.name_status        = out_q.name_status;
  assign out_o.name_length        = out_q.name_length;

  // Checks
  a_value_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_VALUE) |-> (field_left_q != '0))
    else $error("value phase with nothing left in structure");

  a_name_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_name_q |-> (name_res_q == NS_FOUND))
    else $error("inside name structure without name found");

  a_rssi_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && q_entry_i.op == OP_RSSI) |=>
      (out_valid_q && out_q.result_kind == RK_SUMMARY))
    else $error("report end gave no summary");

endmodule

// ----- rtl/ble_adv_report_parser.sv -----
// LE advertising report parser. Takes one report byte per transfer on in_i
// (report_start marks the event type byte) and returns name characters and one
// end-of-report summary per report on out_o. While out_o is not stalled, the
// sustained rate is one byte per clock cycle: the front end classifies a byte in
// the cycle it is accepted, the back end handles one queued byte per cycle. The
// byte queue (QueueDepth entries) lets input keep flowing for that many bytes
// while out_o is stalled; when it fills, in_i.ready drops. Reports may carry up
// to MaxDataBytes of AD data. The user must write max_name_len through
// cfg_we_i/cfg_wdata_i only while idle; the block does not enforce this.
// Uses bap_pkg, bap_in_if, bap_out_if, bap_front, bap_queue, bap_back.
module ble_adv_report_parser import bap_pkg::*; #(
  parameter int unsigned MaxDataBytes = MAX_DATA_BYTES_DEF,
  parameter int unsigned QueueDepth   = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bap_in_if.sink                in_i,
  bap_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [NAME_LEN_W-1:0] cfg_wdata_i
);

  logic [NAME_LEN_W-1:0] max_name_len_q;
  logic                  push, q_full, q_valid, q_pop;
  q_entry_t              push_entry, pop_entry;

  // Name length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_name_len_q <= MAX_NAME_LEN_RST;
    end else if (cfg_we_i) begin
      max_name_len_q <= cfg_wdata_i;
    end
  end

  bap_front #(
    .MaxDataBytes (MaxDataBytes)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  bap_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  bap_back #(
    .MaxDataBytes (MaxDataBytes)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_entry_i      (pop_entry),
    .q_pop_o        (q_pop),
    .max_name_len_i (max_name_len_q),
    .out_o          (out_o)
  );

endmodule
